@@ sv/tcs_pkg.sv @@
// Package: sizes, payload structs and cell constants for the text console.
package tcs_pkg;

   localparam int COLS        = 80;
   localparam int ROWS        = 25;
   localparam int STACK_LINES = 256;

   localparam int SCR_DEPTH = ROWS * COLS;
   localparam int STK_DEPTH = STACK_LINES * COLS;
   localparam int SCR_AW    = $clog2(SCR_DEPTH);
   localparam int STK_AW    = $clog2(STK_DEPTH);
   localparam int ADDR_W    = (SCR_AW > STK_AW) ? SCR_AW : STK_AW;
   localparam int IDX_W     = $clog2(SCR_DEPTH);
   localparam int CNT_W     = $clog2(STACK_LINES + 1);
   localparam int HEAD_W    = (STACK_LINES > 1) ? $clog2(STACK_LINES) : 1;

   localparam logic [1:0] CMD_PUT_CHAR  = 2'd0;
   localparam logic [1:0] CMD_SCROLL_BK = 2'd1;
   localparam logic [1:0] CMD_SCROLL_FW = 2'd2;
   localparam logic [1:0] CMD_READ_CELL = 2'd3;

   localparam logic [7:0]  NL_CHAR     = 8'd10;
   localparam logic [7:0]  BLANK_CHAR  = 8'h20;
   localparam logic [15:0] RESET_CELL  = 16'h0720;
   localparam logic [7:0]  COLOR_RESET = 8'd7;

   localparam logic REG_TEXT_COLOR = 1'b0;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [8:0]  history_lines;
      logic [8:0]  forward_lines;
   } rsp_type;

endpackage

@@ sv/tcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcs_ram #(
   parameter int DEPTH = 2000,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ sv/text_console_with_scrollback_top.sv @@
// Top level: text console with screen, history and forward line stores.
//
// One command is taken when start is high and busy is low; its result is
// shown for one cycle with rsp_valid. A scroll copies lines cell by cell
// through a single copy sequencer; scroll_back skips the push to the
// forward stack when that stack is full, and with empty history copies
// nothing. A put_char that leaves the last row adds a full scroll_forward.
// After reset the screen store is cleared, one cell a cycle, while busy
// is high; register writes are taken at any time.
module text_console_with_scrollback_top
   import tcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PUT, S_CELL_RD, S_CELL_WAIT,
      S_SETUP, S_CP_RD, S_CP_WR, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      J_HPUSH, J_UP, J_BOT, J_FPUSH, J_DOWN, J_TOP
   } job_type;

   typedef enum logic [1:0] { SRC_SCR, SRC_HIST, SRC_FWD, SRC_BLANK } src_type;
   typedef enum logic [1:0] { DST_SCR, DST_HIST, DST_FWD } dst_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   src_type           src_ff, src_in;
   dst_type           dst_ff, dst_in;
   logic              down_ff, down_in;
   logic [ADDR_W-1:0] src_base_ff, src_base_in;
   logic [ADDR_W-1:0] dst_base_ff, dst_base_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   req_type           req_ff, req_in;
   logic [15:0]       cell_ff, cell_in;
   logic [4:0]        row_ff, row_in;
   logic [6:0]        col_ff, col_in;
   logic [CNT_W-1:0]  hc_ff, hc_in;
   logic [CNT_W-1:0]  fc_ff, fc_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [7:0]        color_ff, color_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              scr_we, hist_we, fwd_we;
   logic [SCR_AW-1:0] scr_waddr, scr_raddr;
   logic [STK_AW-1:0] stk_waddr, stk_raddr;
   logic [15:0]       wdata;
   logic [15:0]       scr_rdata, hist_rdata, fwd_rdata;

   logic [HEAD_W-1:0] head_m1, head_p1;
   logic [CNT_W-1:0]  line_sel;
   logic [ADDR_W-1:0] stk_base;
   logic [ADDR_W-1:0] src_addr, dst_addr;
   logic [4:0]        cell_row;
   logic [6:0]        cell_col;
   logic [SCR_AW-1:0] cell_addr;
   logic              cfg_wr;

   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, color_ff} : 32'd0;

   assign head_m1 = (head_ff == '0) ? HEAD_W'(STACK_LINES - 1) : head_ff - 1'b1;
   assign head_p1 = (head_ff == HEAD_W'(STACK_LINES - 1)) ? '0 : head_ff + 1'b1;

   // shared line-base multiplier for stack transfers
   always_comb begin
      unique case (job_ff)
         J_HPUSH: line_sel = CNT_W'(head_ff);
         J_BOT:   line_sel = fc_ff - 1'b1;
         J_FPUSH: line_sel = fc_ff;
         J_TOP:   line_sel = CNT_W'(head_m1);
         default: line_sel = '0;
      endcase
   end
   assign stk_base = ADDR_W'(line_sel * COLS);

   assign src_addr = down_ff ? src_base_ff - ADDR_W'(idx_ff) : src_base_ff + ADDR_W'(idx_ff);
   assign dst_addr = down_ff ? dst_base_ff - ADDR_W'(idx_ff) : dst_base_ff + ADDR_W'(idx_ff);

   assign cell_row  = (state_ff == S_PUT) ? row_ff : req_ff.read_row;
   assign cell_col  = (state_ff == S_PUT) ? col_ff : req_ff.read_col;
   assign cell_addr = SCR_AW'(cell_row * COLS + cell_col);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      down_in      = down_ff;
      src_base_in  = src_base_ff;
      dst_base_in  = dst_base_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      req_in       = req_ff;
      cell_in      = cell_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      hc_in        = hc_ff;
      fc_in        = fc_ff;
      head_in      = head_ff;
      color_in     = (cfg_wr && paddr[2] == REG_TEXT_COLOR) ? pwdata[7:0] : color_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      scr_we       = 1'b0;
      hist_we      = 1'b0;
      fwd_we       = 1'b0;
      scr_waddr    = SCR_AW'(dst_addr);
      stk_waddr    = STK_AW'(dst_addr);
      scr_raddr    = SCR_AW'(src_addr);
      stk_raddr    = STK_AW'(src_addr);
      wdata        = (src_ff == SRC_BLANK) ? {color_ff, BLANK_CHAR} :
                     (src_ff == SRC_HIST)  ? hist_rdata :
                     (src_ff == SRC_FWD)   ? fwd_rdata : scr_rdata;

      unique case (state_ff)
         S_CLEAR: begin
            scr_we    = 1'b1;
            scr_waddr = SCR_AW'(idx_ff);
            wdata     = RESET_CELL;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(SCR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in  = req_data;
               cell_in = '0;
               unique case (req_data.cmd)
                  CMD_PUT_CHAR: state_in = S_PUT;
                  CMD_SCROLL_BK: begin
                     if (hc_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        col_in   = '0;
                        job_in   = (fc_ff < CNT_W'(STACK_LINES)) ? J_FPUSH : J_DOWN;
                        state_in = S_SETUP;
                     end
                  end
                  CMD_SCROLL_FW: begin
                     col_in   = '0;
                     job_in   = J_HPUSH;
                     state_in = S_SETUP;
                  end
                  CMD_READ_CELL: begin
                     if (32'(req_data.read_row) < ROWS && 32'(req_data.read_col) < COLS)
                        state_in = S_CELL_RD;
                     else
                        state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_PUT: begin
            state_in = S_FINISH;
            if (req_ff.char_code != NL_CHAR) begin
               scr_we    = 1'b1;
               scr_waddr = cell_addr;
               wdata     = {color_ff, req_ff.char_code};
            end
            if (req_ff.char_code == NL_CHAR || col_ff == 7'(COLS - 1)) begin
               col_in = '0;
               if (row_ff == 5'(ROWS - 1)) begin
                  job_in   = J_HPUSH;
                  state_in = S_SETUP;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_CELL_RD: begin
            scr_raddr = cell_addr;
            state_in  = S_CELL_WAIT;
         end
         S_CELL_WAIT: begin
            cell_in  = scr_rdata;
            state_in = S_FINISH;
         end
         S_SETUP: begin
            idx_in   = '0;
            down_in  = 1'b0;
            last_in  = IDX_W'(COLS - 1);
            state_in = S_CP_RD;
            unique case (job_ff)
               J_HPUSH: begin
                  src_in = SRC_SCR;  src_base_in = '0;
                  dst_in = DST_HIST; dst_base_in = stk_base;
                  head_in = head_p1;
                  if (hc_ff < CNT_W'(STACK_LINES)) hc_in = hc_ff + 1'b1;
               end
               J_UP: begin
                  src_in = SRC_SCR; src_base_in = ADDR_W'(COLS);
                  dst_in = DST_SCR; dst_base_in = '0;
                  last_in = IDX_W'((ROWS - 1) * COLS - 1);
               end
               J_BOT: begin
                  dst_in = DST_SCR; dst_base_in = ADDR_W'((ROWS - 1) * COLS);
                  if (fc_ff != '0) begin
                     src_in = SRC_FWD; src_base_in = stk_base;
                     fc_in  = fc_ff - 1'b1;
                  end else begin
                     src_in = SRC_BLANK; src_base_in = '0;
                  end
               end
               J_FPUSH: begin
                  src_in = SRC_SCR; src_base_in = ADDR_W'((ROWS - 1) * COLS);
                  dst_in = DST_FWD; dst_base_in = stk_base;
                  fc_in  = fc_ff + 1'b1;
               end
               J_DOWN: begin
                  down_in = 1'b1;
                  src_in  = SRC_SCR; src_base_in = ADDR_W'((ROWS - 1) * COLS - 1);
                  dst_in  = DST_SCR; dst_base_in = ADDR_W'(ROWS * COLS - 1);
                  last_in = IDX_W'((ROWS - 1) * COLS - 1);
               end
               J_TOP: begin
                  src_in  = SRC_HIST; src_base_in = stk_base;
                  dst_in  = DST_SCR;  dst_base_in = '0;
                  head_in = head_m1;
                  hc_in   = hc_ff - 1'b1;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_CP_RD: begin
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            unique case (dst_ff)
               DST_SCR:  scr_we  = 1'b1;
               DST_HIST: hist_we = 1'b1;
               default:  fwd_we  = 1'b1;
            endcase
            if (idx_ff == last_ff) begin
               state_in = S_SETUP;
               unique case (job_ff)
                  J_HPUSH: job_in = J_UP;
                  J_UP:    job_in = J_BOT;
                  J_FPUSH: job_in = J_DOWN;
                  J_DOWN:  job_in = J_TOP;
                  default: state_in = S_FINISH;
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CP_RD;
            end
         end
         S_FINISH: begin
            rsp_valid_in         = 1'b1;
            rsp_in.cell_value    = cell_ff;
            rsp_in.cursor_row    = row_ff;
            rsp_in.cursor_col    = col_ff;
            rsp_in.history_lines = 9'(hc_ff);
            rsp_in.forward_lines = 9'(fc_ff);
            state_in             = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         job_ff       <= J_HPUSH;
         idx_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         hc_ff        <= '0;
         fc_ff        <= '0;
         head_ff      <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         idx_ff       <= idx_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         hc_ff        <= hc_in;
         fc_ff        <= fc_in;
         head_ff      <= head_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      down_ff     <= down_in;
      src_base_ff <= src_base_in;
      dst_base_ff <= dst_base_in;
      last_ff     <= last_in;
      req_ff      <= req_in;
      cell_ff     <= cell_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tcs_ram #(.DEPTH(SCR_DEPTH), .WIDTH(16)) u_screen (
      .clock(clock), .wr_en(scr_we), .wr_addr(scr_waddr), .wr_data(wdata),
      .rd_addr(scr_raddr), .rd_data(scr_rdata)
   );

   tcs_ram #(.DEPTH(STK_DEPTH), .WIDTH(16)) u_history (
      .clock(clock), .wr_en(hist_we), .wr_addr(stk_waddr), .wr_data(wdata),
      .rd_addr(stk_raddr), .rd_data(hist_rdata)
   );

   tcs_ram #(.DEPTH(STK_DEPTH), .WIDTH(16)) u_forward (
      .clock(clock), .wr_en(fwd_we), .wr_addr(stk_waddr), .wr_data(wdata),
      .rd_addr(stk_raddr), .rd_data(fwd_rdata)
   );

endmodule

@@ sv/tcs_checker.sv @@
// Port-level checker for the text console, bound to the top level.
module tcs_checker
   import tcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.cursor_row) < ROWS) && (32'(rsp_data.cursor_col) < COLS)
                 && (32'(rsp_data.history_lines) <= STACK_LINES)
                 && (32'(rsp_data.forward_lines) <= STACK_LINES))
      else $error("cursor or stack count out of range");

endmodule

bind text_console_with_scrollback_top tcs_checker u_tcs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

@@ test/tb.sv @@
// Testbench: directed table and random commands checked against a console predictor.
module tb;
   import tcs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 430;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   text_console_with_scrollback_top i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // console image kept by the predictor
   logic [15:0] scr [SCR_DEPTH];
   logic [15:0] hist [STK_DEPTH];
   logic [15:0] fwd [STK_DEPTH];
   int          hist_cnt, hist_head, fwd_cnt, cur_row, cur_col;
   logic [7:0]  color;

   rsp_type expected_rsp_q[$];
   int      errors = 0;

   // directed rows: request, whether a typed-in result applies, and that result
   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } dir_row_type;
   dir_row_type dir_rows[$];

   function automatic req_type mk_req(logic [1:0] c, logic [7:0] ch, logic [4:0] r,
                                      logic [6:0] k);
      req_type q;
      q.cmd = c; q.char_code = ch; q.read_row = r; q.read_col = k;
      return q;
   endfunction

   function automatic rsp_type mk_rsp(logic [15:0] v, int r, int k, int h, int f);
      rsp_type s;
      s.cell_value = v; s.cursor_row = r[4:0]; s.cursor_col = k[6:0];
      s.history_lines = h[8:0]; s.forward_lines = f[8:0];
      return s;
   endfunction

   task automatic console_reset();
      for (int i = 0; i < SCR_DEPTH; i++) scr[i] = RESET_CELL;
      hist_cnt = 0; hist_head = 0; fwd_cnt = 0; cur_row = 0; cur_col = 0;
      color = COLOR_RESET;
   endtask

   task automatic shift_up();
      for (int c = 0; c < COLS; c++) hist[hist_head*COLS + c] = scr[c];
      hist_head = (hist_head + 1) % STACK_LINES;
      if (hist_cnt < STACK_LINES) hist_cnt++;
      for (int i = 0; i < (ROWS-1)*COLS; i++) scr[i] = scr[i+COLS];
      if (fwd_cnt > 0) begin
         fwd_cnt--;
         for (int c = 0; c < COLS; c++) scr[(ROWS-1)*COLS + c] = fwd[fwd_cnt*COLS + c];
      end else begin
         for (int c = 0; c < COLS; c++) scr[(ROWS-1)*COLS + c] = {color, BLANK_CHAR};
      end
      cur_col = 0;
   endtask

   task automatic shift_down();
      if (hist_cnt == 0) return;
      if (fwd_cnt < STACK_LINES) begin
         for (int c = 0; c < COLS; c++) fwd[fwd_cnt*COLS + c] = scr[(ROWS-1)*COLS + c];
         fwd_cnt++;
      end
      for (int i = SCR_DEPTH-1; i >= COLS; i--) scr[i] = scr[i-COLS];
      hist_head = (hist_head + STACK_LINES - 1) % STACK_LINES;
      hist_cnt--;
      for (int c = 0; c < COLS; c++) scr[c] = hist[hist_head*COLS + c];
      cur_col = 0;
   endtask

   task automatic advance_row();
      cur_row++;
      if (cur_row >= ROWS) begin
         shift_up();
         cur_row = ROWS - 1;
      end
   endtask

   task automatic predict_console(input req_type q, output rsp_type s);
      logic [15:0] cell_val;
      cell_val = '0;
      case (q.cmd)
         CMD_PUT_CHAR: begin
            if (q.char_code == NL_CHAR) begin
               cur_col = 0;
               advance_row();
            end else begin
               scr[cur_row*COLS + cur_col] = {color, q.char_code};
               cur_col++;
               if (cur_col >= COLS) begin
                  cur_col = 0;
                  advance_row();
               end
            end
         end
         CMD_SCROLL_BK: shift_down();
         CMD_SCROLL_FW: shift_up();
         default: begin
            if (q.read_row < ROWS && q.read_col < COLS)
               cell_val = scr[q.read_row*COLS + q.read_col];
         end
      endcase
      s = mk_rsp(cell_val, cur_row, cur_col, hist_cnt, fwd_cnt);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp_q.pop_front();
            if (rsp_data.cell_value !== e.cell_value) begin
               $display("%0t: cell_value exp %h got %h", $time, e.cell_value,
                        rsp_data.cell_value);
               errors++;
            end
            if (rsp_data.cursor_row !== e.cursor_row) begin
               $display("%0t: cursor_row exp %0d got %0d", $time, e.cursor_row,
                        rsp_data.cursor_row);
               errors++;
            end
            if (rsp_data.cursor_col !== e.cursor_col) begin
               $display("%0t: cursor_col exp %0d got %0d", $time, e.cursor_col,
                        rsp_data.cursor_col);
               errors++;
            end
            if (rsp_data.history_lines !== e.history_lines) begin
               $display("%0t: history_lines exp %0d got %0d", $time, e.history_lines,
                        rsp_data.history_lines);
               errors++;
            end
            if (rsp_data.forward_lines !== e.forward_lines) begin
               $display("%0t: forward_lines exp %0d got %0d", $time, e.forward_lines,
                        rsp_data.forward_lines);
               errors++;
            end
         end
      end
   end

   bit no_idle = 1'b0;

   task automatic send_cmd(input req_type q, input bit fixed, input rsp_type fx);
      rsp_type p;
      // start was dropped at a falling edge; raise it on a later one
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(99) < 8) @(negedge clock);
      end
      predict_console(q, p);
      if (fixed && p !== fx) begin
         $display("%0t: table row exp %p predicted %p", $time, fx, p);
         errors++;
      end
      expected_rsp_q.push_back(p);
      req_data <= q;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic write_color(input logic [7:0] v);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 3'(REG_TEXT_COLOR) << 2; pwdata <= {24'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      color = v;
   endtask

   task automatic drain();
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type rand_req();
      req_type q;
      int k;
      k = $urandom_range(99);
      q = mk_req(CMD_PUT_CHAR, 8'($urandom), 5'($urandom), 7'($urandom));
      if (k < 55) begin
         if ($urandom_range(9) == 0) q.char_code = NL_CHAR;
      end else if (k < 62) q.cmd = CMD_SCROLL_BK;
      else if (k < 69) q.cmd = CMD_SCROLL_FW;
      else begin
         q.cmd = CMD_READ_CELL;
         if ($urandom_range(9) != 0) begin
            q.read_row = 5'($urandom_range(ROWS-1));
            q.read_col = 7'($urandom_range(COLS-1));
         end
      end
      return q;
   endfunction

   initial begin
      rsp_type z;
      console_reset();
      z = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset, extremes, empty history, out of range reads
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 0, 0), 1, mk_rsp(RESET_CELL, 0, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 24, 79), 1,
                           mk_rsp(RESET_CELL, 0, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 25, 0), 1, mk_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 31, 127), 1, mk_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 0, 80), 1, mk_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_SCROLL_BK, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_PUT_CHAR, 8'hFF, 31, 127), 1, mk_rsp(0, 0, 1, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_PUT_CHAR, 8'h00, 0, 0), 1, mk_rsp(0, 0, 2, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 0, 0), 1, mk_rsp(16'h07FF, 0, 2, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_PUT_CHAR, NL_CHAR, 0, 0), 1, mk_rsp(0, 1, 0, 0, 0)});
      dir_rows.push_back('{mk_req(CMD_SCROLL_FW, 0, 0, 0), 1, mk_rsp(0, 1, 0, 1, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 24, 5), 1, mk_rsp(16'h0720, 1, 0, 1, 0)});
      dir_rows.push_back('{mk_req(CMD_SCROLL_BK, 0, 0, 0), 1, mk_rsp(0, 1, 0, 0, 1)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 0, 0), 0, z});
      dir_rows.push_back('{mk_req(CMD_SCROLL_FW, 0, 0, 0), 1, mk_rsp(0, 1, 0, 1, 0)});
      dir_rows.push_back('{mk_req(CMD_READ_CELL, 0, 24, 79), 0, z});
      for (int i = 0; i < dir_rows.size(); i++)
         send_cmd(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
      drain();

      // fill a line to wrap, then newlines off the bottom to scroll with new color
      write_color(8'hFF);
      for (int i = 0; i < COLS; i++) send_cmd(mk_req(CMD_PUT_CHAR, 8'h41, 0, 0), 0, z);
      for (int i = 0; i < ROWS; i++) send_cmd(mk_req(CMD_PUT_CHAR, NL_CHAR, 0, 0), 0, z);
      send_cmd(mk_req(CMD_READ_CELL, 0, 24, 0), 0, z);
      drain();

      // random phases with several colors; the third phase never idles
      for (int ph = 0; ph < 4; ph++) begin
         write_color(ph == 0 ? 8'h00 : ph == 3 ? 8'hFF : 8'($urandom));
         no_idle = (ph == 2);
         for (int i = 0; i < N_RANDOM/4; i++) send_cmd(rand_req(), 0, z);
         drain();
      end

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/tcs_pkg.sv
sv/tcs_ram.sv
sv/text_console_with_scrollback_top.sv
sv/tcs_checker.sv
test/tb.sv
